>>> rtl/core/bstp_pkg.sv
// bstp_pkg: types and constants shared by the band slot table policy unit
// slot entry layout, scan unit result, request codes, status codes, sequencer states
// no dependencies
`default_nettype none

package bstp_pkg;

  // relay flag nibble bits
  localparam logic [3:0] FLAG_RELAY       = 4'h1;
  localparam logic [3:0] FLAG_TUNE        = 4'h2;
  localparam logic [3:0] FLAG_UNKNOWN     = 4'h4;
  localparam logic [3:0] FLAG_UNCONNECTED = 4'h8;

  // use count ceiling
  localparam logic [7:0] USE_MAX = 8'd255;

  // one stored slot, inductor in the low bits
  typedef struct packed {
    logic [7:0] use_cnt;
    logic [3:0] flags;
    logic [7:0] cap;
    logic [7:0] ind;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // contents of a slot that was never written since reset or erase
  localparam entry_t ENTRY_RESET = '{use_cnt: 8'd0, flags: FLAG_TUNE, cap: 8'd0, ind: 8'd0};

  // request kinds
  typedef enum logic [1:0] {
    ACT_SAVE      = 2'd0,
    ACT_ERASE     = 2'd1,
    ACT_ERASE_ALL = 2'd2,
    ACT_RELOAD    = 2'd3
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NO_SLOT   = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_USE,
    S_DUP,
    S_PICK,
    S_AGE,
    S_PLACE,
    S_OUT
  } state_e;

  // per-entry verdicts from the shared scan unit
  typedef struct packed {
    logic       dup;
    logic       elig;
    logic       less;
    logic       more;
    logic       zero;
    logic [7:0] aged_use;
  } scan_t;

  // one result item
  typedef struct packed {
    logic [3:0] flags;
    logic [7:0] cap;
    logic [7:0] ind;
    logic       relay_valid;
    logic [5:0] slot;
    status_e    status;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/bstp_ram.sv
// bstp_ram: generic single write port, single read port RAM with registered read
// no dependencies
`default_nettype none

module bstp_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/bstp_unit.sv
// bstp_unit: shared compare and decrement unit applied to one slot entry per cycle
// depends on bstp_pkg
`default_nettype none

module bstp_unit
  import bstp_pkg::*;
(
  input  wire entry_t      entry_i,
  input  wire logic [7:0]  key_l_i,
  input  wire logic [7:0]  key_c_i,
  input  wire logic        key_relay_i,
  input  wire logic [7:0]  min_i,
  input  wire logic [7:0]  max_i,
  output scan_t            scan_o
);

  // duplicate test on inductor, capacitor and relay bit
  assign scan_o.dup = (entry_i.ind == key_l_i) && (entry_i.cap == key_c_i) &&
                      (entry_i.flags[0] == key_relay_i);

  // slot may be overwritten when unconnected or tune
  assign scan_o.elig = ((entry_i.flags & (FLAG_UNCONNECTED | FLAG_TUNE)) != 4'd0);

  // use count against running minimum and maximum
  assign scan_o.less = (entry_i.use_cnt < min_i);
  assign scan_o.more = (entry_i.use_cnt > max_i);
  assign scan_o.zero = (entry_i.use_cnt == 8'd0);

  // ageing, floored at zero
  assign scan_o.aged_use = scan_o.zero ? 8'd0 : (entry_i.use_cnt - 8'd1);

endmodule

`default_nettype wire

>>> rtl/core/band_slot_table_policy_unit.sv
// band_slot_table_policy_unit: top level, slot table sequencer with shared scan unit
// depends on bstp_pkg, bstp_ram, bstp_unit
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid_i/tready_o   tuser: action; tdata: band, relay_l, relay_c,
//                                           relay_i, connected
//  m_axis   out  m_axis_tvalid_o/tready_i   tuser: status; tdata: slot_index, relay_valid,
//                                           out_l, out_c, out_flags
//
// erase, erase all and out-of-range requests go from decode to output; reload and
// connected save pass the read state in between; an unconnected save scans the table
// once for duplicates and once for the least used slot, plus one more read-modify-write
// sweep when ageing, the single RAM read port feeding the scan unit one slot per cycle
// reset clears slot valid bits at once, so no clearing pass is needed
// input is refused while a request is in work; a result waiting on m_axis stalls only
// the hand-over of the next result
`default_nettype none

module band_slot_table_policy_unit
  import bstp_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // band[5:0], relay_l[13:6], relay_c[21:14],
                                             // relay_i[25:22], connected[26], zero pad
  input  wire logic [1:0]  s_axis_tuser_i,   // action[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [31:0] m_axis_tdata_o,   // slot_index[5:0], relay_valid[6], out_l[14:7],
                                             // out_c[22:15], out_flags[26:23], zero pad
  output logic      [1:0]  m_axis_tuser_o    // status[1:0]
);

  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned IW = $clog2(SLOT_COUNT + 1);

  // sequencer and scan state
  state_e            state_q, state_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              dv_q, dv_d;
  logic [AW-1:0]     didx_q, didx_d;
  logic              found_q, found_d;
  logic              stop_q, stop_d;
  logic [7:0]        min_q, min_d;
  logic [7:0]        max_q, max_d;
  logic [AW-1:0]     chosen_q, chosen_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;

  // captured request
  action_e           act_q, act_d;
  logic [5:0]        band_q, band_d;
  logic [7:0]        l_q, l_d;
  logic [7:0]        c_q, c_d;
  logic [3:0]        i_q, i_d;
  logic              conn_q, conn_d;

  // pending and presented results
  res_t              res_q, res_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // memory and scan unit wiring
  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;
  logic [AW-1:0]     raddr;
  logic [ENTRY_W-1:0] rdata;
  entry_t            eff;
  scan_t             scan;
  logic              issue;
  logic              in_range;
  logic [AW-1:0]     slot;
  logic              accept;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_range = (band_q != 6'd0) && ({1'b0, band_q} <= 7'(SLOT_COUNT));
  assign slot     = AW'(band_q - 6'd1);
  assign issue    = (idx_q < IW'(SLOT_COUNT));

  // never-written slots read as their reset contents
  assign eff = valid_q[didx_q] ? entry_t'(rdata) : ENTRY_RESET;

  bstp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bstp_unit u_unit (
    .entry_i     (eff),
    .key_l_i     (l_q),
    .key_c_i     (c_q),
    .key_relay_i (i_q[0]),
    .min_i       (min_q),
    .max_i       (max_q),
    .scan_o      (scan)
  );

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      dv_q        <= 1'b0;
      found_q     <= 1'b0;
      stop_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      dv_q        <= dv_d;
      found_q     <= found_d;
      stop_q      <= stop_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    didx_q   <= didx_d;
    min_q    <= min_d;
    max_q    <= max_d;
    chosen_q <= chosen_d;
    act_q    <= act_d;
    band_q   <= band_d;
    l_q      <= l_d;
    c_q      <= c_d;
    i_q      <= i_d;
    conn_q   <= conn_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    dv_d        = dv_q;
    didx_d      = didx_q;
    found_d     = found_q;
    stop_d      = stop_q;
    min_d       = min_q;
    max_d       = max_q;
    chosen_d    = chosen_q;
    valid_d     = valid_q;
    act_d       = act_q;
    band_d      = band_q;
    l_d         = l_q;
    c_d         = c_q;
    i_d         = i_q;
    conn_d      = conn_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    we          = 1'b0;
    waddr       = didx_q;
    wdata       = eff;
    raddr       = idx_q[AW-1:0];
    s_axis_tready_o = 1'b0;

    // scan walk: one read issued and one entry checked per cycle
    if (state_q == S_DUP || state_q == S_PICK || state_q == S_AGE) begin
      dv_d = issue;
      if (issue) begin
        idx_d  = idx_q + IW'(1);
        didx_d = idx_q[AW-1:0];
      end
    end

    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          act_d   = action_e'(s_axis_tuser_i);
          band_d  = s_axis_tdata_i[5:0];
          l_d     = s_axis_tdata_i[13:6];
          c_d     = s_axis_tdata_i[21:14];
          i_d     = s_axis_tdata_i[25:22];
          conn_d  = s_axis_tdata_i[26];
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        res_d = '{flags: 4'd0, cap: 8'd0, ind: 8'd0, relay_valid: 1'b0, slot: 6'd0,
                  status: ST_RANGE};
        case (act_q)
          ACT_SAVE: begin
            if (!conn_q) begin
              idx_d   = '0;
              dv_d    = 1'b0;
              state_d = S_DUP;
            end else if (in_range) begin
              raddr   = slot;
              didx_d  = slot;
              state_d = S_RD_USE;
            end else begin
              state_d = S_OUT;
            end
          end
          ACT_ERASE: begin
            if (in_range) begin
              valid_d[slot] = 1'b0;
              res_d = '{flags: FLAG_TUNE, cap: 8'd0, ind: 8'd0, relay_valid: 1'b1,
                        slot: 6'(slot), status: ST_DONE};
            end
            state_d = S_OUT;
          end
          ACT_ERASE_ALL: begin
            valid_d = '0;
            res_d = '{flags: FLAG_TUNE, cap: 8'd0, ind: 8'd0, relay_valid: 1'b1,
                      slot: 6'd0, status: ST_DONE};
            state_d = S_OUT;
          end
          ACT_RELOAD: begin
            if (in_range) begin
              raddr   = slot;
              didx_d  = slot;
              state_d = S_RD_USE;
            end else begin
              state_d = S_OUT;
            end
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end

      S_RD_USE: begin
        if (act_q == ACT_RELOAD) begin
          if ((eff.flags & FLAG_UNKNOWN) != 4'd0) begin
            res_d = '{flags: FLAG_TUNE, cap: 8'd0, ind: 8'd0, relay_valid: 1'b1,
                      slot: 6'(didx_q), status: ST_DONE};
          end else begin
            res_d = '{flags: eff.flags, cap: eff.cap, ind: eff.ind, relay_valid: 1'b1,
                      slot: 6'(didx_q), status: ST_DONE};
          end
        end else begin
          // connected save keeps the use count
          we              = 1'b1;
          wdata           = '{use_cnt: eff.use_cnt, flags: i_q, cap: c_q, ind: l_q};
          valid_d[didx_q] = 1'b1;
          res_d = '{flags: 4'd0, cap: 8'd0, ind: 8'd0, relay_valid: 1'b0,
                    slot: 6'(didx_q), status: ST_DONE};
        end
        state_d = S_OUT;
      end

      S_DUP: begin
        if (dv_q && scan.dup) begin
          res_d = '{flags: 4'd0, cap: 8'd0, ind: 8'd0, relay_valid: 1'b0,
                    slot: 6'(didx_q), status: ST_DUPLICATE};
          state_d = S_OUT;
        end else if (!issue && !dv_q) begin
          idx_d    = '0;
          dv_d     = 1'b0;
          found_d  = 1'b0;
          stop_d   = 1'b0;
          min_d    = 8'd0;
          max_d    = 8'd0;
          chosen_d = '0;
          state_d  = S_PICK;
        end
      end

      S_PICK: begin
        // least used eligible slot, stopping at the first unused one
        if (dv_q && !stop_q && scan.elig) begin
          if (!found_q || scan.less) begin
            min_d    = eff.use_cnt;
            chosen_d = didx_q;
          end
          if (scan.more) begin
            max_d = eff.use_cnt;
          end
          found_d = 1'b1;
          if (scan.zero) begin
            stop_d = 1'b1;
          end
        end
        if (!issue && !dv_q) begin
          if (!found_q) begin
            res_d = '{flags: 4'd0, cap: 8'd0, ind: 8'd0, relay_valid: 1'b0,
                      slot: 6'd0, status: ST_NO_SLOT};
            state_d = S_OUT;
          end else if (min_q > 8'd1) begin
            idx_d   = '0;
            dv_d    = 1'b0;
            state_d = S_AGE;
          end else begin
            state_d = S_PLACE;
          end
        end
      end

      S_AGE: begin
        // write back each stored slot with its count lowered
        if (dv_q && valid_q[didx_q]) begin
          we    = 1'b1;
          wdata = '{use_cnt: scan.aged_use, flags: eff.flags, cap: eff.cap, ind: eff.ind};
        end
        if (!issue && !dv_q) begin
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        we                = 1'b1;
        waddr             = chosen_q;
        wdata             = '{use_cnt: (max_q == USE_MAX) ? USE_MAX : (max_q + 8'd1),
                              flags: i_q | FLAG_UNCONNECTED, cap: c_q, ind: l_q};
        valid_d[chosen_q] = 1'b1;
        res_d = '{flags: 4'd0, cap: 8'd0, ind: 8'd0, relay_valid: 1'b0,
                  slot: 6'(chosen_q), status: ST_DONE};
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output port packing
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {5'd0, out_q.flags, out_q.cap, out_q.ind, out_q.relay_valid,
                            out_q.slot};

  // scans for duplicates and for the least used slot never modify the table
  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUP || state_q == S_PICK) |-> !we)
    else $error("table written during a read-only scan");

  // a slot is only placed after an eligible one was found
  a_place_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLACE) |-> found_q)
    else $error("placement without an eligible slot");

  // ageing only runs when the smallest count exceeds one
  a_age_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AGE) |-> (min_q > 8'd1))
    else $error("ageing started with minimum count of one or less");

  // an accepted request closes the input until its result is handed over
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("input reopened right after accepting a request");

endmodule

`default_nettype wire
